/* src/tdil_pkg.sv */
// ----------------------------------------------------------------------------
// tdil_pkg
// Shared constants and types for the 3x3 threshold dilation block.
// ----------------------------------------------------------------------------
package tdil_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

    localparam logic [PIX_W-1:0] DARK_LIMIT = 8'd127;
    localparam logic [PIX_W-1:0] BRIGHT     = 8'd255;

    // Line buffer access for one cycle
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } tdil_lb_ctl_t;

    // Border and output flags of the beat held in the window stage
    typedef struct packed {
        logic emit;
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
        logic last;
    } tdil_pos_t;

endpackage

/* src/tdil_line_buf.sv */
// ----------------------------------------------------------------------------
// tdil_line_buf
// Two row buffers (two rows back, one row back) with registered read and
// forwarding of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
module tdil_line_buf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tdil_pkg::tdil_lb_ctl_t     ctl,
    input  logic [tdil_pkg::PIX_W-1:0] wr_older,
    input  logic [tdil_pkg::PIX_W-1:0] wr_newer,
    output logic [tdil_pkg::PIX_W-1:0] rd_top,
    output logic [tdil_pkg::PIX_W-1:0] rd_mid
);
    import tdil_pkg::*;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

    logic [PIX_W-1:0] rd_older_reg;
    logic [PIX_W-1:0] rd_newer_reg;
    logic [PIX_W-1:0] byp_older_reg;
    logic [PIX_W-1:0] byp_newer_reg;
    logic             hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            older_mem[ctl.wr_addr] <= wr_older;
            newer_mem[ctl.wr_addr] <= wr_newer;
        end
        if (ctl.rd_en) begin
            rd_older_reg  <= older_mem[ctl.rd_addr];
            rd_newer_reg  <= newer_mem[ctl.rd_addr];
            byp_older_reg <= wr_older;
            byp_newer_reg <= wr_newer;
        end
    end

    // Read returns old data on a same-address write: take the write data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl.rd_en) begin
            hit_reg <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
        end
    end

    assign rd_top = hit_reg ? byp_older_reg : rd_older_reg;
    assign rd_mid = hit_reg ? byp_newer_reg : rd_newer_reg;

endmodule

/* src/threshold_dilate_3x3_top.sv */
// ----------------------------------------------------------------------------
// threshold_dilate_3x3_top
// Streaming 3x3 threshold dilation with edge replication.
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock cycle unless output back-pressure
// holds the window stage. A beat passes through the line buffer read
// (window) stage and then the result register; the line buffer is read
// once per accepted beat. In raster terms the result for pixel
// k comes with input beat k + width + 1, so a frame needs width*height pixel
// beats followed by width+1 flush beats (mode = 1); the last result of the
// frame carries frame_last. A write to either size register restarts the
// frame position; write only while no beat is in flight.
module threshold_dilate_3x3_top (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [tdil_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdil_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [tdil_pkg::PIX_W-1:0]      s_pixel_in,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tdil_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                            m_frame_last
);
    import tdil_pkg::*;

    // Configuration
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    // Raster position of the next beat
    logic [COL_W-1:0] in_column_reg;
    logic [COL_W-1:0] in_column_next;
    logic [ROW_W-1:0] in_row_reg;
    logic [ROW_W-1:0] in_row_next;

    // Window stage
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    tdil_pos_t        s1_pos_reg;
    logic             s1_move;

    // Two stored window columns (left, centre), rows top..bottom
    logic [PIX_W-1:0] win_reg [6];

    // Result register
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_pixel_reg;
    logic             m_last_reg;

    logic             accept;
    logic [PIX_W-1:0] pix_in;
    tdil_pos_t        pos;
    logic [COL_W-1:0] x;
    logic [Y_W-1:0]   y;

    tdil_lb_ctl_t     lb_ctl;
    logic [PIX_W-1:0] lb_top;
    logic [PIX_W-1:0] lb_mid;

    logic [PIX_W-1:0] nb [3][3];
    logic [PIX_W-1:0] centre;
    logic             any_bright;
    logic [PIX_W-1:0] result;

    // ------------------------------------------------------------------
    // Effective frame size
    // ------------------------------------------------------------------
    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (image_width_reg > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (image_height_reg > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = image_height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input side: position of the output pixel this beat completes
    // ------------------------------------------------------------------
    assign s1_move = s1_valid_reg && (!s1_pos_reg.emit || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_move;
    assign accept  = s_valid && s_ready;
    assign pix_in  = s_mode ? '0 : s_pixel_in;

    always_comb begin
        pos.emit = (in_row_reg >= ROW_W'(2)) ||
                   ((in_row_reg == ROW_W'(1)) && (in_column_reg != '0));
        if (in_column_reg != '0) begin
            x = in_column_reg - COL_W'(1);
            y = Y_W'(in_row_reg - ROW_W'(1));
        end else begin
            x = COL_W'(w_eff - WIDTH_W'(1));
            y = Y_W'(in_row_reg - ROW_W'(2));
        end
        pos.first_row = (y == '0);
        pos.last_row  = ({1'b0, y} + HEIGHT_W'(1)) >= h_eff;
        pos.first_col = (x == '0);
        pos.last_col  = ({1'b0, x} + WIDTH_W'(1)) >= w_eff;
        pos.last      = pos.emit && pos.last_row && pos.last_col;
    end

    always_comb begin
        in_column_next = in_column_reg;
        in_row_next    = in_row_reg;
        if (accept) begin
            if (({1'b0, in_column_reg} + WIDTH_W'(1)) >= w_eff) begin
                in_column_next = '0;
                in_row_next    = in_row_reg + ROW_W'(1);
            end else begin
                in_column_next = in_column_reg + COL_W'(1);
            end
            // Frame done: restart the raster
            if (pos.last) begin
                in_column_next = '0;
                in_row_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            in_column_reg    <= '0;
            in_row_reg       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_data[WIDTH_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_data[HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
            in_column_reg <= '0;
            in_row_reg    <= '0;
        end else begin
            in_column_reg <= in_column_next;
            in_row_reg    <= in_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: read on accept, write back when the beat leaves
    // ------------------------------------------------------------------
    assign lb_ctl.rd_en   = accept;
    assign lb_ctl.rd_addr = in_column_reg;
    assign lb_ctl.wr_en   = s1_move;
    assign lb_ctl.wr_addr = s1_col_reg;

    tdil_line_buf u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (lb_ctl),
        .wr_older (lb_mid),
        .wr_newer (s1_pix_reg),
        .rd_top   (lb_top),
        .rd_mid   (lb_mid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg <= pix_in;
            s1_col_reg <= in_column_reg;
            s1_pos_reg <= pos;
        end
    end

    // ------------------------------------------------------------------
    // Window and threshold kernel
    // ------------------------------------------------------------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            nb[0][r] = win_reg[r];
            nb[1][r] = win_reg[3 + r];
        end
        nb[2][0] = lb_top;
        nb[2][1] = lb_mid;
        nb[2][2] = s1_pix_reg;

        // Replicate border rows, then border columns
        for (int c = 0; c < 3; c++) begin
            if (s1_pos_reg.first_row) begin
                nb[c][0] = nb[c][1];
            end
            if (s1_pos_reg.last_row) begin
                nb[c][2] = nb[c][1];
            end
        end
        if (s1_pos_reg.first_col) begin
            for (int r = 0; r < 3; r++) begin
                nb[0][r] = nb[1][r];
            end
        end
        if (s1_pos_reg.last_col) begin
            for (int r = 0; r < 3; r++) begin
                nb[2][r] = nb[1][r];
            end
        end

        centre     = nb[1][1];
        any_bright = 1'b0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (!((c == 1) && (r == 1)) && (nb[c][r] > DARK_LIMIT)) begin
                    any_bright = 1'b1;
                end
            end
        end

        if (centre < DARK_LIMIT) begin
            result = any_bright ? BRIGHT : '0;
        end else begin
            result = centre;
        end
    end

    // Shift the window by one column per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_move) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i] <= win_reg[3 + i];
            end
            win_reg[3] <= lb_top;
            win_reg[4] <= lb_mid;
            win_reg[5] <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move && s1_pos_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && s1_pos_reg.emit) begin
            m_pixel_reg <= result;
            m_last_reg  <= s1_pos_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    column_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, in_column_reg} < w_eff))
        else $error("column counter outside the row");

    frame_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pos.last && !cfg_wr_en) |=> (in_column_reg == '0 && in_row_reg == '0))
        else $error("raster position not restarted after frame end");

    stall_only_on_full_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_move) |-> (m_valid_reg && !m_ready))
        else $error("window stage held without output back-pressure");

    last_is_bottom_right: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_pos_reg.last) |-> (s1_pos_reg.last_col && s1_pos_reg.last_row))
        else $error("frame end flagged away from the bottom-right pixel");

endmodule
